// ===== hw/rtl/crrc_pkg.sv =====
// Shared types and constants for the CAN receive rolling-counter checker.
// No dependencies.
`default_nettype none

package crrc_pkg;

    // Verdict codes carried on the result transfer
    typedef enum logic [1:0] {
        VERDICT_ACCEPT    = 2'd0,
        VERDICT_MALFORMED = 2'd1,
        VERDICT_CHECKSUM  = 2'd2,
        VERDICT_REPLAY    = 2'd3
    } verdict_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_INTEGRITY_ENABLE = 1'b0,
        CFG_EXPECTED_LENGTH  = 1'b1
    } cfg_index_t;

    // Control states: table clear after reset, then normal running
    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } state_t;

    localparam int unsigned LENGTH_BITS      = 4;
    localparam int unsigned CFG_DATA_BITS    = 4;
    localparam int unsigned TOTAL_BITS       = 32;
    localparam logic        RESET_INTEGRITY  = 1'b1;
    localparam logic [LENGTH_BITS-1:0] RESET_LENGTH = 4'd8;

endpackage : crrc_pkg

`default_nettype wire

// ===== hw/rtl/crrc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module crrc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : crrc_ram

`default_nettype wire

// ===== hw/rtl/can_rx_rolling_counter_checker.sv =====
// Top level of the CAN receive rolling-counter checker.
// Depends on crrc_pkg and crrc_ram.
`default_nettype none

// Checks received CAN frames one transfer at a time and returns one verdict per
// frame: accepted, malformed (length code differs from expected_length, or the
// extended, remote or error flag is set), checksum failure, or replay (rolling
// counter equal to the last one stored for that identifier). An accepted frame
// whose counter is not the stored value plus one is flagged with gap_seen. The
// checksum, replay and gap checks apply only while integrity is enabled. Four
// saturating error counters are presented with every result. The last counter
// per identifier sits in a 2^ID_BITS-entry RAM. After reset the block clears
// that RAM, one entry per cycle, with in_ready held low; configuration writes
// are taken throughout. After that a frame passes a RAM read, then check and
// write-back, and a new frame is taken every cycle unless the output stalls:
// the most recent table write is forwarded, so frames with the same identifier
// can follow each other directly. The one read-modify-write of the table per
// frame sets throughput. The result sits in an output register, so the next
// frame is taken while a result waits for out_ready. Users must write
// configuration only while the block is idle; the block does not enforce it.
module can_rx_rolling_counter_checker
    import crrc_pkg::*;
#(
    parameter int unsigned ID_BITS      = 11,
    parameter int unsigned COUNTER_BITS = 4,
    parameter int unsigned COUNT_BITS   = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    // configuration write port
    input  wire logic                     cfg_we,
    input  wire logic                     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,

    // frame input
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [10:0]              can_id,
    input  wire logic                     extended_flag,
    input  wire logic                     remote_flag,
    input  wire logic                     error_flag,
    input  wire logic [3:0]               length_code,
    input  wire logic [3:0]               rolling_value,
    input  wire logic                     checksum_good,

    // result output
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [1:0]                    verdict,
    output logic                          gap_seen,
    output logic [TOTAL_BITS-1:0]         malformed_total,
    output logic [TOTAL_BITS-1:0]         checksum_total,
    output logic [TOTAL_BITS-1:0]         replay_total,
    output logic [TOTAL_BITS-1:0]         gap_total
);

    localparam int unsigned DEPTH      = 2 ** ID_BITS;
    localparam int unsigned ENTRY_BITS = COUNTER_BITS + 1;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic                   integrity_reg;
    logic [LENGTH_BITS-1:0] exp_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integrity_reg <= RESET_INTEGRITY;
            exp_len_reg   <= RESET_LENGTH;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_INTEGRITY_ENABLE: integrity_reg <= cfg_data[0];
                CFG_EXPECTED_LENGTH:  exp_len_reg   <= cfg_data[LENGTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Control: table clear after reset, then run
    // ---------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [ID_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic               clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        clearing      = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clearing      = 1'b1;
                clr_addr_next = clr_addr_reg + ID_BITS'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: ;
            default: state_next = ST_CLEAR;
        endcase
    end

    // ---------------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------------
    logic b_valid_reg;
    logic out_valid_reg;
    logic b_go;
    logic in_xfer;

    assign b_go     = b_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clearing && (!b_valid_reg || b_go);
    assign in_xfer  = in_valid && in_ready;

    // ---------------------------------------------------------------------
    // Stage A: capture frame, issue table read
    // ---------------------------------------------------------------------
    logic [ID_BITS-1:0]      b_id_reg;
    logic [COUNTER_BITS-1:0] b_ctr_reg;
    logic                    b_malformed_reg;
    logic                    b_sum_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (b_go)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            b_id_reg        <= can_id[ID_BITS-1:0];
            b_ctr_reg       <= COUNTER_BITS'(rolling_value);
            b_malformed_reg <= (length_code != exp_len_reg) || extended_flag
                               || remote_flag || error_flag;
            b_sum_ok_reg    <= checksum_good;
        end
    end

    // ---------------------------------------------------------------------
    // Counter table: entry = {valid, counter}
    // ---------------------------------------------------------------------
    logic                  ram_we;
    logic [ID_BITS-1:0]    ram_waddr;
    logic [ENTRY_BITS-1:0] ram_wdata;
    logic [ENTRY_BITS-1:0] ram_rdata;
    logic                  upd_we;

    assign ram_we    = clearing || upd_we;
    assign ram_waddr = clearing ? clr_addr_reg : b_id_reg;
    assign ram_wdata = clearing ? '0 : {1'b1, b_ctr_reg};

    crrc_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_xfer),
        .raddr (can_id[ID_BITS-1:0]),
        .rdata (ram_rdata)
    );

    // Last table update; always the newest value for its address, so it
    // covers a read issued in the same cycle as the write.
    logic                    lw_valid_reg;
    logic [ID_BITS-1:0]      lw_addr_reg;
    logic [COUNTER_BITS-1:0] lw_ctr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_valid_reg <= 1'b0;
        end
        else if (upd_we)
        begin
            lw_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_we)
        begin
            lw_addr_reg <= b_id_reg;
            lw_ctr_reg  <= b_ctr_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Stage B: check and write back
    // ---------------------------------------------------------------------
    logic                    e_valid;
    logic [COUNTER_BITS-1:0] e_ctr;
    verdict_t                verdict_b;
    logic                    gap_b;

    always_comb
    begin
        if (lw_valid_reg && (lw_addr_reg == b_id_reg))
        begin
            e_valid = 1'b1;
            e_ctr   = lw_ctr_reg;
        end
        else
        begin
            e_valid = ram_rdata[COUNTER_BITS];
            e_ctr   = ram_rdata[COUNTER_BITS-1:0];
        end

        verdict_b = VERDICT_ACCEPT;
        gap_b     = 1'b0;
        upd_we    = 1'b0;
        if (b_malformed_reg)
        begin
            verdict_b = VERDICT_MALFORMED;
        end
        else if (integrity_reg)
        begin
            if (!b_sum_ok_reg)
            begin
                verdict_b = VERDICT_CHECKSUM;
            end
            else if (e_valid && (e_ctr == b_ctr_reg))
            begin
                verdict_b = VERDICT_REPLAY;
            end
            else
            begin
                gap_b  = e_valid && (b_ctr_reg != (e_ctr + COUNTER_BITS'(1)));
                upd_we = b_go;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Saturating error counters; they move only when a result is loaded,
    // so they double as the totals of the result held in the output stage.
    // ---------------------------------------------------------------------
    logic [COUNT_BITS-1:0] malformed_cnt_reg;
    logic [COUNT_BITS-1:0] checksum_cnt_reg;
    logic [COUNT_BITS-1:0] replay_cnt_reg;
    logic [COUNT_BITS-1:0] gap_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            malformed_cnt_reg <= '0;
            checksum_cnt_reg  <= '0;
            replay_cnt_reg    <= '0;
            gap_cnt_reg       <= '0;
        end
        else if (b_go)
        begin
            if (verdict_b == VERDICT_MALFORMED && malformed_cnt_reg != '1)
            begin
                malformed_cnt_reg <= malformed_cnt_reg + COUNT_BITS'(1);
            end
            if (verdict_b == VERDICT_CHECKSUM && checksum_cnt_reg != '1)
            begin
                checksum_cnt_reg <= checksum_cnt_reg + COUNT_BITS'(1);
            end
            if (verdict_b == VERDICT_REPLAY && replay_cnt_reg != '1)
            begin
                replay_cnt_reg <= replay_cnt_reg + COUNT_BITS'(1);
            end
            if (gap_b && gap_cnt_reg != '1)
            begin
                gap_cnt_reg <= gap_cnt_reg + COUNT_BITS'(1);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    verdict_t verdict_reg;
    logic     gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (b_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_go)
        begin
            verdict_reg <= verdict_b;
            gap_reg     <= gap_b;
        end
    end

    assign out_valid       = out_valid_reg;
    assign verdict         = verdict_reg;
    assign gap_seen        = gap_reg;
    assign malformed_total = TOTAL_BITS'(malformed_cnt_reg);
    assign checksum_total  = TOTAL_BITS'(checksum_cnt_reg);
    assign replay_total    = TOTAL_BITS'(replay_cnt_reg);
    assign gap_total       = TOTAL_BITS'(gap_cnt_reg);

endmodule : can_rx_rolling_counter_checker

`default_nettype wire
